[rtl/core/calendar_date_advance_core_macros.svh]
// assertion helpers for the calendar date core
// both expect clk_i and rst_ni in the scope of the use
`ifndef CALENDAR_DATE_ADVANCE_CORE_MACROS_SVH
`define CALENDAR_DATE_ADVANCE_CORE_MACROS_SVH

// same-cycle implication
`define CDA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar date core: same-cycle check failed");

// next-cycle implication
`define CDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar date core: next-cycle check failed");

`endif

[rtl/core/cda_pkg.sv]
package cda_pkg;

  // field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned WD_W     = 3;
  localparam int unsigned STATUS_W = 2;

  // parameter defaults
  localparam int unsigned DEF_MAX_YEAR      = 9999;
  localparam int unsigned DEF_MAX_DAY_COUNT = 1023;

  // reset date
  localparam logic [YEAR_W-1:0]  RST_YEAR  = YEAR_W'(2001);
  localparam logic [MONTH_W-1:0] RST_MONTH = MONTH_W'(1);
  localparam logic [DAY_W-1:0]   RST_DAY   = DAY_W'(1);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_LAST  = DAY_W'(31);

  // reciprocal multiplier: operand * K >> SHIFT gives the floor quotient
  localparam int unsigned MUL_A_W  = 15;
  localparam int unsigned MUL_K_W  = 16;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_K_W;
  localparam int unsigned Q100_W   = 8;
  localparam int unsigned RECIP_25_K     = 2622;   // ceil(2^16 / 25)
  localparam int unsigned RECIP_25_SHIFT = 16;
  localparam int unsigned RECIP_7_K      = 37450;  // ceil(2^18 / 7)
  localparam int unsigned RECIP_7_SHIFT  = 18;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    RECIP_25 = 1'b0,
    RECIP_7  = 1'b1
  } recip_e;

  typedef struct packed {
    logic                 en;
    recip_e               sel;
    logic [MUL_A_W-1:0]   operand;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_DIV,
    ST_LD_CHK,
    ST_ADV_START,
    ST_ADV_DIV,
    ST_ADV_STEP,
    ST_WD_DIV,
    ST_WD_SUM,
    ST_WD_MOD,
    ST_WD_FIN,
    ST_DONE
  } state_e;

  // q100 is floor(year / 100)
  function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                   input logic [Q100_W-1:0] q100);
    logic [YEAR_W:0] hundreds;
    logic            by_100;
    hundreds = ((YEAR_W+1)'(q100) << 6) + ((YEAR_W+1)'(q100) << 5)
             + ((YEAR_W+1)'(q100) << 2);
    by_100   = (hundreds == (YEAR_W+1)'(year));
    return (year[1:0] == 2'b00) && (!by_100 || (q100[1:0] == 2'b00));
  endfunction

  // zero for a month outside 1 to 12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

  // weekday month offsets
  function automatic logic [WD_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
    logic [WD_W-1:0] off;
    unique case (month)
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

[rtl/core/cda_recip_mul.sv]
module cda_recip_mul (
  input  logic                             clk_i,
  input  cda_pkg::mul_req_t                req_i,
  output logic [cda_pkg::MUL_A_W-1:0]      quot_o
);
  import cda_pkg::*;

  logic [MUL_K_W-1:0] k;
  logic [MUL_P_W-1:0] prod_q;
  recip_e             sel_q;

  always_comb begin
    unique case (req_i.sel)
      RECIP_7:  k = MUL_K_W'(RECIP_7_K);
      RECIP_25: k = MUL_K_W'(RECIP_25_K);
      default:  k = MUL_K_W'(RECIP_25_K);
    endcase
  end

  // product holds until the next request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MUL_P_W'(req_i.operand) * MUL_P_W'(k);
      sel_q  <= req_i.sel;
    end
  end

  always_comb begin
    unique case (sel_q)
      RECIP_7:  quot_o = MUL_A_W'(prod_q >> RECIP_7_SHIFT);
      RECIP_25: quot_o = MUL_A_W'(prod_q >> RECIP_25_SHIFT);
      default:  quot_o = MUL_A_W'(prod_q >> RECIP_25_SHIFT);
    endcase
  end

endmodule

[rtl/core/calendar_date_advance_core.sv]
// gregorian date counter with load and advance commands
// input channel: in_valid_i / in_stall_o carries one command transaction
//   (command, year_in, month_in, day_in, day_count); out channel:
//   out_valid_o / out_stall_i carries one result transaction per command
//   (year, month, day, weekday, status)
// a load checks the date against the year range, month lengths and the leap rule; a bad
//   date leaves the stored date alone and reports invalid status
// an advance walks one month per cycle (plus a leap divide per year) and
//   saturates at december 31 of MAX_YEAR with overflow status
// one transaction at a time: in_stall_o is high from acceptance until the
//   result is written to the output register
// sequence: a load passes the leap divide, the date check and the weekday
//   states before out_valid_o; an advance with a zero count skips the walk,
//   otherwise it walks month by month and redoes the leap divide per year
//   crossed; the month walk and the single shared reciprocal multiplier
//   (leap test and weekday mod 7) make up these steps
// the next transaction can be taken in the same cycle that out_valid_o rises
// a stalled result stays in the output register; the core parks until the
//   register frees, then takes the next transaction
// reset gives 2001-01-01 and an empty output register
`include "calendar_date_advance_core_macros.svh"

module calendar_date_advance_core #(
  parameter int unsigned MAX_YEAR      = cda_pkg::DEF_MAX_YEAR,
  parameter int unsigned MAX_DAY_COUNT = cda_pkg::DEF_MAX_DAY_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cda_pkg::CMD_W-1:0]         command_i,
  input  logic [cda_pkg::YEAR_W-1:0]        year_in_i,
  input  logic [cda_pkg::MONTH_W-1:0]       month_in_i,
  input  logic [cda_pkg::DAY_W-1:0]         day_in_i,
  input  logic [cda_pkg::CNT_W-1:0]         day_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cda_pkg::YEAR_W-1:0]        year_out_o,
  output logic [cda_pkg::MONTH_W-1:0]       month_out_o,
  output logic [cda_pkg::DAY_W-1:0]         day_out_o,
  output logic [cda_pkg::WD_W-1:0]          weekday_o,
  output logic [cda_pkg::STATUS_W-1:0]      status_o
);
  import cda_pkg::*;

  localparam logic [YEAR_W:0]  MaxYearExt = (YEAR_W+1)'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] MaxYear   = YEAR_W'(MAX_YEAR);
  localparam int unsigned CntFull = (1 << CNT_W) - 1;
  localparam int unsigned CntCap  = (MAX_DAY_COUNT < CntFull) ? MAX_DAY_COUNT : CntFull;
  localparam logic [CNT_W-1:0] CntCapV = CNT_W'(CntCap);

  // sequencer and stored date
  state_e             state_q, state_d;
  logic [YEAR_W-1:0]  cur_year_q, cur_year_d;
  logic [MONTH_W-1:0] cur_month_q, cur_month_d;
  logic [DAY_W-1:0]   cur_day_q, cur_day_d;
  logic               out_valid_q, out_valid_d;

  // captured command and working registers
  logic [YEAR_W-1:0]  yin_q, yin_d;
  logic [MONTH_W-1:0] min_q, min_d;
  logic [DAY_W-1:0]   din_q, din_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  status_e            status_q, status_d;
  logic [MUL_A_W-1:0] sum_q, sum_d;
  logic [WD_W-1:0]    wd_q, wd_d;

  // output register payload
  logic [YEAR_W-1:0]  oyear_q, oyear_d;
  logic [MONTH_W-1:0] omonth_q, omonth_d;
  logic [DAY_W-1:0]   oday_q, oday_d;
  logic [WD_W-1:0]    owd_q, owd_d;
  status_e            ostatus_q, ostatus_d;

  mul_req_t           mul_req;
  logic [MUL_A_W-1:0] quot;

  logic               out_free;
  logic [YEAR_W-1:0]  probe_year;
  logic               leap;
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   left;
  logic               fits;
  logic               year_over;
  logic               next_year_over;
  logic [DAY_W-1:0]   ld_len;
  logic               ld_ok;
  logic [YEAR_W-1:0]  wd_year;
  logic [Q100_W-1:0]  q100;
  logic [MUL_A_W:0]   seven_q;

  cda_recip_mul u_recip_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .quot_o (quot)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // the product register holds floor(year / 100) for the year that was asked
  assign q100       = Q100_W'(quot);
  assign probe_year = (state_q == ST_LD_CHK) ? yin_q : cur_year_q;
  assign leap       = is_leap(probe_year, q100);

  // month walk
  assign cur_len        = month_len(cur_month_q, leap);
  assign left           = (cur_len > cur_day_q) ? cur_len - cur_day_q : '0;
  assign fits           = ((CNT_W)'(left) >= cnt_q);
  assign year_over      = ((YEAR_W+1)'(cur_year_q) > MaxYearExt);
  assign next_year_over = ((YEAR_W+1)'(cur_year_q) + (YEAR_W+1)'(1) > MaxYearExt);

  // load check
  assign ld_len = month_len(min_q, leap);
  assign ld_ok  = (yin_q != '0) && ((YEAR_W+1)'(yin_q) <= MaxYearExt)
               && (din_q != '0) && (din_q <= ld_len);

  // january and february count with the year before
  assign wd_year = ((cur_month_q < MONTH_MAR) && (cur_year_q != '0)) ?
                   cur_year_q - YEAR_W'(1) : cur_year_q;

  assign seven_q = ((MUL_A_W+1)'(quot) << 3) - (MUL_A_W+1)'(quot);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == CMD_LOAD) ? ST_LD_DIV : ST_ADV_START;
        end
      end
      ST_LD_DIV:    state_d = ST_LD_CHK;
      ST_LD_CHK:    state_d = ST_WD_DIV;
      ST_ADV_START: begin
        if ((cnt_q == '0) || year_over) begin
          state_d = ST_WD_DIV;
        end else begin
          state_d = ST_ADV_DIV;
        end
      end
      ST_ADV_DIV:   state_d = ST_ADV_STEP;
      ST_ADV_STEP: begin
        priority if (fits) begin
          state_d = ST_WD_DIV;
        end else if (cur_month_q >= MONTH_DEC) begin
          state_d = next_year_over ? ST_WD_DIV : ST_ADV_DIV;
        end else begin
          state_d = ST_ADV_STEP;
        end
      end
      ST_WD_DIV:    state_d = ST_WD_SUM;
      ST_WD_SUM:    state_d = ST_WD_MOD;
      ST_WD_MOD:    state_d = ST_WD_FIN;
      ST_WD_FIN:    state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and unit requests
  always_comb begin
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    yin_d       = yin_q;
    min_d       = min_q;
    din_d       = din_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    sum_d       = sum_q;
    wd_d        = wd_q;
    oyear_d     = oyear_q;
    omonth_d    = omonth_q;
    oday_d      = oday_q;
    owd_d       = owd_q;
    ostatus_d   = ostatus_q;
    mul_req     = '{en: 1'b0, sel: RECIP_25, operand: '0};

    unique case (state_q)
      ST_IDLE: begin
        yin_d    = year_in_i;
        min_d    = month_in_i;
        din_d    = day_in_i;
        cnt_d    = (day_count_i > CntCapV) ? CntCapV : day_count_i;
        status_d = STATUS_OK;
      end
      ST_LD_DIV: begin
        mul_req = '{en: 1'b1, sel: RECIP_25, operand: MUL_A_W'(yin_q >> 2)};
      end
      ST_LD_CHK: begin
        if (ld_ok) begin
          cur_year_d  = yin_q;
          cur_month_d = min_q;
          cur_day_d   = din_q;
        end else begin
          status_d = STATUS_INVALID;
        end
      end
      ST_ADV_START: begin
        if ((cnt_q != '0) && year_over) begin
          cur_year_d  = MaxYear;
          cur_month_d = MONTH_DEC;
          cur_day_d   = DAY_LAST;
          status_d    = STATUS_OVERFLOW;
        end
      end
      ST_ADV_DIV: begin
        mul_req = '{en: 1'b1, sel: RECIP_25, operand: MUL_A_W'(cur_year_q >> 2)};
      end
      ST_ADV_STEP: begin
        if (fits) begin
          cur_day_d = cur_day_q + DAY_W'(cnt_q);
        end else begin
          cnt_d     = cnt_q - CNT_W'(left) - CNT_W'(1);
          cur_day_d = DAY_FIRST;
          if (cur_month_q >= MONTH_DEC) begin
            if (next_year_over) begin
              cur_year_d  = MaxYear;
              cur_month_d = MONTH_DEC;
              cur_day_d   = DAY_LAST;
              status_d    = STATUS_OVERFLOW;
            end else begin
              cur_year_d  = cur_year_q + YEAR_W'(1);
              cur_month_d = MONTH_JAN;
            end
          end else begin
            cur_month_d = cur_month_q + MONTH_W'(1);
          end
        end
      end
      ST_WD_DIV: begin
        mul_req = '{en: 1'b1, sel: RECIP_25, operand: MUL_A_W'(wd_year >> 2)};
      end
      ST_WD_SUM: begin
        sum_d = MUL_A_W'(wd_year) + MUL_A_W'(wd_year >> 2) - MUL_A_W'(q100)
              + MUL_A_W'(q100 >> 2) + MUL_A_W'(month_offset(cur_month_q))
              + MUL_A_W'(cur_day_q);
      end
      ST_WD_MOD: begin
        mul_req = '{en: 1'b1, sel: RECIP_7, operand: sum_q};
      end
      ST_WD_FIN: begin
        wd_d = WD_W'((MUL_A_W+1)'(sum_q) - seven_q);
      end
      ST_DONE: begin
        if (out_free) begin
          oyear_d   = cur_year_q;
          omonth_d  = cur_month_q;
          oday_d    = cur_day_q;
          owd_d     = wd_q;
          ostatus_d = status_q;
        end
      end
      default: begin
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    priority if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_year_q  <= RST_YEAR;
      cur_month_q <= RST_MONTH;
      cur_day_q   <= RST_DAY;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yin_q     <= yin_d;
    min_q     <= min_d;
    din_q     <= din_d;
    cnt_q     <= cnt_d;
    status_q  <= status_d;
    sum_q     <= sum_d;
    wd_q      <= wd_d;
    oyear_q   <= oyear_d;
    omonth_q  <= omonth_d;
    oday_q    <= oday_d;
    owd_q     <= owd_d;
    ostatus_q <= ostatus_d;
  end

  assign out_valid_o = out_valid_q;
  assign year_out_o  = oyear_q;
  assign month_out_o = omonth_q;
  assign day_out_o   = oday_q;
  assign weekday_o   = owd_q;
  assign status_o    = ostatus_q;

  // an accepted transaction always starts the sequencer
  `CDA_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q != ST_IDLE)

  // stored date stays a real date between transactions
  `CDA_ASSERT_NOW(a_date_sane, state_q == ST_IDLE,
    cur_month_q >= MONTH_JAN && cur_month_q <= MONTH_DEC && cur_day_q != '0)

  // overflow results always carry the saturated date
  `CDA_ASSERT_NOW(a_overflow_date, out_valid_o && status_o == STATUS_OVERFLOW,
    year_out_o == MaxYear && month_out_o == MONTH_DEC && day_out_o == DAY_LAST)

  // weekday reduction lands in range
  `CDA_ASSERT_NOW(a_weekday_range, out_valid_o, weekday_o != 3'd7)

endmodule
